[sv/stes_pkg.sv]
// ----------------------------------------------------------------------------
// stes_pkg: shared two-ended stack types and codes
// Transfer payload types, operation and status codes and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package stes_pkg;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic STACK_LOW  = 1'b0;
   localparam logic STACK_HIGH = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic               which_stack;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] pop_value;
      logic [7:0]         low_count;
      logic [7:0]         high_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

[sv/stes_ctrl.sv]
// ----------------------------------------------------------------------------
// stes_ctrl: transfer sequencing for the shared two-ended stack
// Takes an item, runs the execute state in the datapath and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module stes_ctrl
   import stes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_DONE) && !rsp_stall));
   assign rsp_valid = (state_ff == S_DONE);
   assign take      = req_valid && !req_stall;

   always_comb begin
      cmd.load = take;
      cmd.exec = (state_ff == S_EXEC);
      case (state_ff)
         S_IDLE: begin
            state_in = take ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_stall) begin
               state_in = S_DONE;
            end else if (take) begin
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/stes_dpath.sv]
// ----------------------------------------------------------------------------
// stes_dpath: shared two-ended stack datapath
// Item register, both stack counts, the shared word memory and the
// result register.
// ----------------------------------------------------------------------------
module stes_dpath
   import stes_pkg::*;
#(
   parameter int DEPTH = 128
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
   localparam logic [AW-1:0] TOP_ADDR = AW'(DEPTH - 1);

   logic [31:0] mem [DEPTH];

   req_type       item_ff;
   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] high_ff, high_in;
   logic [1:0]    status_ff, status_in;
   logic          popped_ff, popped_in;
   logic [31:0]   rd_data_ff;

   logic [CW:0]   used;
   logic          full;
   logic [CW-1:0] low_m1, high_m1;
   logic          wr_en, rd_en;
   logic [AW-1:0] addr;
   logic [CW+7:0] low_ext, high_ext;

   assign used    = {1'b0, low_ff} + {1'b0, high_ff};
   assign full    = (used >= DEPTH_W);
   assign low_m1  = low_ff - 1'b1;
   assign high_m1 = high_ff - 1'b1;

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      status_in = ST_DONE;
      popped_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = low_ff[AW-1:0];
      case (item_ff.func)
         FUNC_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (item_ff.which_stack == STACK_LOW) begin
               wr_en  = 1'b1;
               addr   = low_ff[AW-1:0];
               low_in = low_ff + 1'b1;
            end else begin
               wr_en   = 1'b1;
               addr    = TOP_ADDR - high_ff[AW-1:0];
               high_in = high_ff + 1'b1;
            end
         end
         FUNC_POP: begin
            if (item_ff.which_stack == STACK_LOW) begin
               if (low_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  popped_in = 1'b1;
                  addr      = low_m1[AW-1:0];
                  low_in    = low_m1;
               end
            end else begin
               if (high_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  popped_in = 1'b1;
                  addr      = TOP_ADDR - high_m1[AW-1:0];
                  high_in   = high_m1;
               end
            end
         end
         FUNC_CLEAR: begin
            if (item_ff.which_stack == STACK_LOW) begin
               low_in = '0;
            end else begin
               high_in = '0;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
      end
      if (cmd.exec && wr_en) begin
         mem[addr] <= item_ff.push_value;
      end
      if (cmd.exec && rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else if (cmd.exec) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign low_ext  = {8'd0, low_ff};
   assign high_ext = {8'd0, high_ff};

   assign rsp_data.status     = status_ff;
   assign rsp_data.pop_value  = popped_ff ? rd_data_ff : 32'd0;
   assign rsp_data.low_count  = low_ext[7:0];
   assign rsp_data.high_count = high_ext[7:0];

endmodule

[sv/shared_two_ended_stack_unit.sv]
// ----------------------------------------------------------------------------
// shared_two_ended_stack_unit: two stacks in one shared word memory
// Usage:
//   req_ channel carries one operation (push, pop or clear) on the low or
//   high stack; a transfer completes when req_valid is high and req_stall
//   is low. rsp_ channel returns exactly one result per item: status, the
//   popped word and both stack counts after the item.
//   A transferred request passes through the item register, executes
//   against the memory in the execute state, and its result (memory read
//   data included) is registered in the result register.
//   When the receiver does not stall, a new request is taken in the same
//   cycle the previous result transfers.
//   The item register and the execute state do not overlap, so no new item
//   is taken while the previous one executes.
//   While the receiver stalls, the result holds and req_stall stays high.
//   Reset empties both stacks; memory contents are not cleared and are
//   only ever read after being written.
// ----------------------------------------------------------------------------
module shared_two_ended_stack_unit
   import stes_pkg::*;
#(
   parameter int DEPTH = 128
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;

   stes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   stes_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid ##1 rsp_valid)
      else $error("result not presented two cycles after request transfer");

   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result is stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_EMPTY))
      else $error("illegal status code");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |-> (rsp_data.pop_value == 32'sd0))
      else $error("refused operation returned a word");

endmodule
